// ----- design/ppbad_pkg.sv -----
// shared types, constants and the duty scaling table for the pump pwm drive
`default_nettype none

package ppbad_pkg;

	localparam int PCT_W      = 7;
	localparam int MS_W       = 16;
	localparam int TIME_W     = 32;
	localparam int DUTY_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int PCT_FULL       = 100;
	localparam int DUTY_BITS_DEF  = 8;

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	// register reset values
	localparam logic [PCT_W-1:0] MIN_DUTY_RST   = 7'd10;
	localparam logic [PCT_W-1:0] MAX_DUTY_RST   = 7'd100;
	localparam logic [MS_W-1:0]  BOOST_LEN_RST  = 16'd700;
	localparam logic [PCT_W-1:0] ASSIST_MAX_RST = 7'd10;
	localparam logic [MS_W-1:0]  KICK_MS_RST    = 16'd80;
	localparam logic [MS_W-1:0]  INTERVAL_RST   = 16'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_DUTY    = 3'd0,
		CFG_MAX_DUTY    = 3'd1,
		CFG_BOOST_LEN   = 3'd2,
		CFG_ASSIST_EN   = 3'd3,
		CFG_ASSIST_MAX  = 3'd4,
		CFG_KICK_MS     = 3'd5,
		CFG_INTERVAL_MS = 3'd6,
		CFG_ACTIVE_HIGH = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [PCT_W-1:0] min_duty_percent;
		logic [PCT_W-1:0] max_duty_percent;
		logic [MS_W-1:0]  boost_len;
		logic             assist_enable;
		logic [PCT_W-1:0] assist_max_speed_percent;
		logic [MS_W-1:0]  assist_kick_ms;
		logic [MS_W-1:0]  assist_interval_ms;
		logic             active_high;
	} cfg_t;

	typedef struct packed {
		logic              pump_enable;
		logic [PCT_W-1:0]  speed_percent;
		logic [TIME_W-1:0] time_ms;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_count;
		logic              running;
		logic              boost_now;
		logic              assist_now;
		logic [PCT_W-1:0]  mapped_percent;
	} result_t;

	typedef logic [DUTY_W-1:0] duty_lut_t [PCT_FULL+1];

	// percent to pwm counts, truncated, low byte kept
	function automatic duty_lut_t build_duty_lut(input int bits);
		duty_lut_t lut;
		int        full;
		full = (1 << bits) - 1;
		for (int p = 0; p <= PCT_FULL; p++) begin
			lut[p] = DUTY_W'((p * full) / PCT_FULL);
		end
		return lut;
	endfunction

endpackage

`default_nettype wire

// ----- design/ppbad_ifs.sv -----
// valid/ready channel interfaces for samples, drive results and register writes
`default_nettype none

interface ppbad_in_if;
	import ppbad_pkg::*;
	logic              valid;
	logic              ready;
	logic              pump_enable;
	logic [PCT_W-1:0]  speed_percent;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, pump_enable, speed_percent, time_ms, input ready);
	modport sink   (input valid, pump_enable, speed_percent, time_ms, output ready);
endinterface

interface ppbad_out_if;
	import ppbad_pkg::*;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_count;
	logic              running;
	logic              boost_now;
	logic              assist_now;
	logic [PCT_W-1:0]  mapped_percent;

	modport source (output valid, duty_count, running, boost_now, assist_now,
		mapped_percent, input ready);
	modport sink   (input valid, duty_count, running, boost_now, assist_now,
		mapped_percent, output ready);
endinterface

interface ppbad_cfg_if;
	import ppbad_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/ppbad_cfg.sv -----
// configuration register file
`default_nettype none

module ppbad_cfg
	import ppbad_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_duty_percent         <= MIN_DUTY_RST;
			cfg_q.max_duty_percent         <= MAX_DUTY_RST;
			cfg_q.boost_len                <= BOOST_LEN_RST;
			cfg_q.assist_enable            <= 1'b0;
			cfg_q.assist_max_speed_percent <= ASSIST_MAX_RST;
			cfg_q.assist_kick_ms           <= KICK_MS_RST;
			cfg_q.assist_interval_ms       <= INTERVAL_RST;
			cfg_q.active_high              <= 1'b1;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_MIN_DUTY:    cfg_q.min_duty_percent         <= wr_data[PCT_W-1:0];
				CFG_MAX_DUTY:    cfg_q.max_duty_percent         <= wr_data[PCT_W-1:0];
				CFG_BOOST_LEN:   cfg_q.boost_len                <= wr_data[MS_W-1:0];
				CFG_ASSIST_EN:   cfg_q.assist_enable            <= wr_data[0];
				CFG_ASSIST_MAX:  cfg_q.assist_max_speed_percent <= wr_data[PCT_W-1:0];
				CFG_KICK_MS:     cfg_q.assist_kick_ms           <= wr_data[MS_W-1:0];
				CFG_INTERVAL_MS: cfg_q.assist_interval_ms       <= wr_data[MS_W-1:0];
				CFG_ACTIVE_HIGH: cfg_q.active_high              <= wr_data[0];
				default:         ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- design/ppbad_core.sv -----
// duty mapping, boost and assist timing with the per-pump state
`default_nettype none

module ppbad_core
	import ppbad_pkg::*;
#(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic advance,
	input  item_t     item,
	input  cfg_t      cfg,
	output result_t   result
);

	localparam duty_lut_t         DUTY_LUT    = build_duty_lut(DUTY_BITS);
	localparam logic [DUTY_W-1:0] DUTY_MAX_LO = DUTY_W'((1 << DUTY_BITS) - 1);

	logic              was_running_q;
	logic              boost_pending_q;
	logic [TIME_W-1:0] boost_start_q;
	logic [TIME_W-1:0] kick_start_q;

	logic              on;
	logic              rise;
	logic [PCT_W-1:0]  req;
	logic [PCT_W-1:0]  minp;
	logic [PCT_W-1:0]  maxp_lo;
	logic [PCT_W-1:0]  maxp;
	logic [PCT_W-1:0]  mapped;
	logic              pend_eff;
	logic [TIME_W-1:0] elapsed_b;
	logic              boost_now;
	logic [TIME_W-1:0] ks_eff;
	logic [TIME_W-1:0] elapsed_k;
	logic              restart;
	logic [TIME_W-1:0] elapsed_eff;
	logic              assist_cond;
	logic              assist_now;
	logic [PCT_W-1:0]  applied;
	logic [DUTY_W-1:0] lut_val;

	always_comb begin
		on   = item.pump_enable && (item.speed_percent != '0);
		rise = on && !was_running_q;
		req  = (item.speed_percent > PCT_MAX) ? PCT_MAX : item.speed_percent;

		// duty window, max pulled up to min then capped at full scale
		minp    = (cfg.min_duty_percent > PCT_MAX) ? PCT_MAX : cfg.min_duty_percent;
		maxp_lo = (cfg.max_duty_percent < minp) ? minp : cfg.max_duty_percent;
		maxp    = (maxp_lo > PCT_MAX) ? PCT_MAX : maxp_lo;

		mapped = '0;
		if (on) begin
			mapped = req;
			if (mapped < minp) mapped = minp;
			if (mapped > maxp) mapped = maxp;
		end

		// boost window, wrap-safe elapsed time
		pend_eff  = rise ? (cfg.boost_len != '0) : boost_pending_q;
		elapsed_b = rise ? '0 : (item.time_ms - boost_start_q);
		boost_now = on && pend_eff && (elapsed_b < {{(TIME_W-MS_W){1'b0}}, cfg.boost_len});

		// assist kicks
		ks_eff      = rise ? item.time_ms : kick_start_q;
		elapsed_k   = item.time_ms - ks_eff;
		restart     = elapsed_k >= {{(TIME_W-MS_W){1'b0}}, cfg.assist_interval_ms};
		elapsed_eff = restart ? '0 : elapsed_k;
		assist_cond = cfg.assist_enable && on && !boost_now
			&& (req <= cfg.assist_max_speed_percent);
		assist_now  = assist_cond
			&& (elapsed_eff < {{(TIME_W-MS_W){1'b0}}, cfg.assist_kick_ms});

		applied = (boost_now || assist_now) ? PCT_MAX : mapped;
		lut_val = DUTY_LUT[applied];

		result.duty_count     = cfg.active_high ? lut_val : (DUTY_MAX_LO - lut_val);
		result.running        = on;
		result.boost_now      = boost_now;
		result.assist_now     = assist_now;
		result.mapped_percent = mapped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_running_q   <= 1'b0;
			boost_pending_q <= 1'b0;
			boost_start_q   <= '0;
			kick_start_q    <= '0;
		end else if (advance) begin
			was_running_q   <= on;
			boost_pending_q <= boost_now;
			if (!on) begin
				boost_start_q <= '0;
				kick_start_q  <= '0;
			end else begin
				if (rise) boost_start_q <= item.time_ms;
				kick_start_q <= (assist_cond && restart) ? item.time_ms : ks_eff;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/pump_pwm_boost_assist_drive.sv -----
// Pump PWM drive: one sample beat in (enable, speed percent, millisecond time),
// one drive beat out (duty count, running, boost and assist flags, mapped percent).
// The sample is captured in an input register, the duty, boost and assist
// decisions are worked out in one pass of short logic and land in an output
// register. While the drive side keeps up, a new sample beat is taken every clock
// and throughput is one beat per cycle, set by the single state update per beat
// in the core; the drive beat is offered once past the input and output
// registers, later while the drive side stalls. Registers are written through
// the cfg channel, which is always ready; write them only while the block is
// idle. The duty table is built at elaboration from DUTY_BITS.
`default_nettype none

module pump_pwm_boost_assist_drive
	import ppbad_pkg::*;
#(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ppbad_in_if.sink     sample,
	ppbad_out_if.source  drive,
	ppbad_cfg_if.sink    cfg
);

	cfg_t    cfg_regs;
	item_t   item_s1;
	logic    valid_s1;
	result_t core_res;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;
	logic    take;

	// register file, writes land at once
	assign cfg.ready = 1'b1;

	ppbad_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// a beat moves on when the output register is free or being drained
	assign advance      = valid_s1 && (!res_valid_q || drive.ready);
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.pump_enable   <= sample.pump_enable;
			item_s1.speed_percent <= sample.speed_percent;
			item_s1.time_ms       <= sample.time_ms;
		end
	end

	// mapping and timing, state steps once per advancing beat
	ppbad_core #(
		.DUTY_BITS (DUTY_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_regs),
		.result  (core_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (drive.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign drive.valid          = res_valid_q;
	assign drive.duty_count     = res_q.duty_count;
	assign drive.running        = res_q.running;
	assign drive.boost_now      = res_q.boost_now;
	assign drive.assist_now     = res_q.assist_now;
	assign drive.mapped_percent = res_q.mapped_percent;

endmodule

`default_nettype wire

// ----- design/ppbad_chk.sv -----
// port-level checks for the pump pwm drive, bound to the top level
`default_nettype none

module ppbad_chk
	import ppbad_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             running,
	input wire logic             boost_now,
	input wire logic             assist_now,
	input wire logic [PCT_W-1:0] mapped_percent
);

	// an idle pump shows no overrides and a zero mapped percent
	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !running) |-> (!boost_now && !assist_now && mapped_percent == '0))
		else $error("override or duty shown while pump off");

	// assist kicks never overlap the startup boost
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(boost_now && assist_now))
		else $error("boost and assist both active");

	// a running pump always has a mapped percent no higher than full scale
	a_mapped_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && running) |-> (mapped_percent <= PCT_MAX))
		else $error("mapped percent out of range");

	// a waiting drive beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("drive beat dropped while stalled");

endmodule

bind pump_pwm_boost_assist_drive ppbad_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (drive.valid),
	.out_ready      (drive.ready),
	.running        (drive.running),
	.boost_now      (drive.boost_now),
	.assist_now     (drive.assist_now),
	.mapped_percent (drive.mapped_percent)
);

`default_nettype wire

// ----- dv/pump_pwm_boost_assist_drive_test.sv -----
// self-checking testbench for the pump pwm drive with boost and assist kicks
module pump_pwm_boost_assist_drive_test;
	import ppbad_pkg::*;

	// counts at full duty for the default duty width
	localparam int DUTY_FULL   = (1 << DUTY_BITS_DEF) - 1;
	// cycles with no beat on any channel before the run is called dead
	localparam int QUIET_LIMIT = 2000;
	// length of the long receiver hold-off
	localparam int HOLD_CYCLES = 48;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 128;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ppbad_in_if  sample_ch ();
	ppbad_out_if drive_ch ();
	ppbad_cfg_if cfg_ch ();

	pump_pwm_boost_assist_drive u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.drive  (drive_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// shadow of the register bank, kept in step with every accepted write
	cfg_t        shadow_cfg;
	// shadow of the drive state
	logic        was_on;
	logic        boost_armed;
	logic [31:0] boost_t0;
	logic [31:0] kick_t0;

	// drive beats still owed by the block, oldest first
	result_t     expected_drive [$];
	int          fault_count = 0;
	int          quiet_cycles = 0;

	// idling knobs, changed per phase
	int          stall_pct = 20;
	bit          gaps_on = 1'b0;
	bit          hold_req = 1'b0;

	// free-running millisecond clock and pump request of the stimulus
	logic [31:0] sim_ms;
	bit          pump_req;

	// expected drive beat for one sample beat, advancing the shadow state
	function automatic result_t predict_drive(input item_t it);
		result_t     r;
		logic        on;
		logic        boost_act;
		logic        assist_act;
		logic [31:0] req;
		logic [31:0] minp;
		logic [31:0] maxp;
		logic [31:0] mapped;
		logic [31:0] elapsed;
		logic [31:0] applied;
		logic [31:0] duty;

		on  = it.pump_enable && (it.speed_percent != '0);
		req = 32'd0;
		if (on) begin
			req = (it.speed_percent > PCT_MAX) ? 32'(PCT_MAX) : 32'(it.speed_percent);
		end

		// duty window: min saturates at full, max pulled into [min, full]
		minp = (shadow_cfg.min_duty_percent > PCT_MAX) ? 32'(PCT_MAX)
			: 32'(shadow_cfg.min_duty_percent);
		maxp = 32'(shadow_cfg.max_duty_percent);
		if (maxp < minp) maxp = minp;
		if (maxp > PCT_FULL) maxp = PCT_FULL;

		mapped = 32'd0;
		if (on) begin
			mapped = req;
			if (mapped < minp) mapped = minp;
			if (mapped > maxp) mapped = maxp;
		end

		// rising edge of running opens the boost window and restarts kick timing
		if (on && !was_on) begin
			boost_armed = (shadow_cfg.boost_len != '0);
			boost_t0    = it.time_ms;
			kick_t0     = it.time_ms;
		end
		if (!on) begin
			boost_armed = 1'b0;
			boost_t0    = 32'd0;
			kick_t0     = 32'd0;
		end

		// wrap-safe elapsed time against the live boost length
		elapsed   = it.time_ms - boost_t0;
		boost_act = boost_armed && (elapsed < 32'(shadow_cfg.boost_len));
		if (!boost_act) boost_armed = 1'b0;

		assist_act = 1'b0;
		if (shadow_cfg.assist_enable && on && !boost_act
			&& req <= 32'(shadow_cfg.assist_max_speed_percent)) begin
			elapsed = it.time_ms - kick_t0;
			if (elapsed >= 32'(shadow_cfg.assist_interval_ms)) begin
				kick_t0 = it.time_ms;
				elapsed = 32'd0;
			end
			assist_act = elapsed < 32'(shadow_cfg.assist_kick_ms);
		end

		applied = (boost_act || assist_act) ? 32'(PCT_FULL) : mapped;
		duty    = applied * DUTY_FULL / PCT_FULL;
		if (!shadow_cfg.active_high) duty = DUTY_FULL - duty;

		was_on = on;

		r.duty_count     = duty[DUTY_W-1:0];
		r.running        = on;
		r.boost_now      = boost_act;
		r.assist_now     = assist_act;
		r.mapped_percent = mapped[PCT_W-1:0];
		return r;
	endfunction

	task automatic report_fault(input string msg);
		fault_count++;
		$display("%0t drive mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] seen,
		input logic [31:0] want);
		if (seen !== want) begin
			report_fault($sformatf("%s got %0h expected %0h", name, seen, want));
		end
	endtask

	// offer one sample beat and hold it until taken
	task automatic send_sample(input logic en, input logic [PCT_W-1:0] spd,
		input logic [TIME_W-1:0] t);
		item_t it;

		it.pump_enable   = en;
		it.speed_percent = spd;
		it.time_ms       = t;
		@(negedge clk);
		sample_ch.valid         = 1'b1;
		sample_ch.pump_enable   = it.pump_enable;
		sample_ch.speed_percent = it.speed_percent;
		sample_ch.time_ms       = it.time_ms;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		expected_drive.push_back(predict_drive(it));
	endtask

	task automatic pause_sample(input int cycles);
		@(negedge clk);
		sample_ch.valid = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// stop offering, let every owed beat come out, then cover the pipeline depth
	task automatic drain_results();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (expected_drive.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_MIN_DUTY:    shadow_cfg.min_duty_percent         = val[PCT_W-1:0];
			CFG_MAX_DUTY:    shadow_cfg.max_duty_percent         = val[PCT_W-1:0];
			CFG_BOOST_LEN:   shadow_cfg.boost_len                = val[MS_W-1:0];
			CFG_ASSIST_EN:   shadow_cfg.assist_enable            = val[0];
			CFG_ASSIST_MAX:  shadow_cfg.assist_max_speed_percent = val[PCT_W-1:0];
			CFG_KICK_MS:     shadow_cfg.assist_kick_ms           = val[MS_W-1:0];
			CFG_INTERVAL_MS: shadow_cfg.assist_interval_ms       = val[MS_W-1:0];
			CFG_ACTIVE_HIGH: shadow_cfg.active_high              = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic [PCT_W-1:0] pick_pct();
		case ($urandom_range(0, 7))
			0:       return 7'd0;
			1:       return PCT_MAX;
			2:       return 7'd127;
			3:       return 7'd101;
			4:       return 7'($urandom_range(1, 20));
			default: return 7'($urandom_range(0, 100));
		endcase
	endfunction

	function automatic logic [MS_W-1:0] pick_ms();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(1, 50));
			default: return 16'($urandom_range(1, 3000));
		endcase
	endfunction

	// defaults after reset: pump off, zero speed, boost window across the time wrap
	task automatic test_reset_defaults();
		send_sample(1'b0, 7'd50, 32'd0);
		send_sample(1'b1, 7'd0, 32'd5);
		send_sample(1'b1, 7'd127, 32'hFFFF_FF00);
		// 699 ms later, past the wrap, still boosting
		send_sample(1'b1, 7'd1, 32'h0000_01BB);
		// 700 ms: window closed
		send_sample(1'b1, 7'd100, 32'h0000_01BC);
		send_sample(1'b1, 7'd5, 32'h0000_0200);
		send_sample(1'b0, 7'd127, 32'h0000_0300);
	endtask

	// duty window extremes and active-low polarity
	task automatic test_duty_window();
		drain_results();
		write_reg(CFG_MIN_DUTY, 16'd127);
		write_reg(CFG_MAX_DUTY, 16'd0);
		write_reg(CFG_BOOST_LEN, 16'd0);
		write_reg(CFG_ACTIVE_HIGH, 16'd0);
		// min above full saturates, max pulled up to it, no boost
		send_sample(1'b1, 7'd1, 32'd100);
		send_sample(1'b1, 7'd127, 32'd110);
		// pump off while active low gives full counts
		send_sample(1'b0, 7'd0, 32'd120);
		drain_results();
		write_reg(CFG_MIN_DUTY, 16'd0);
		write_reg(CFG_ACTIVE_HIGH, 16'd1);
		send_sample(1'b1, 7'd64, 32'd130);
	endtask

	// boost at its longest, assist with zero interval, zero kick and interval rollover
	task automatic test_assist_kicks();
		drain_results();
		write_reg(CFG_MAX_DUTY, 16'd127);
		write_reg(CFG_BOOST_LEN, 16'hFFFF);
		write_reg(CFG_ASSIST_EN, 16'd1);
		write_reg(CFG_ASSIST_MAX, 16'd127);
		write_reg(CFG_KICK_MS, 16'd80);
		write_reg(CFG_INTERVAL_MS, 16'd0);
		send_sample(1'b0, 7'd0, 32'd900);
		send_sample(1'b1, 7'd50, 32'd1000);
		send_sample(1'b1, 7'd50, 32'd1000 + 32'd65534);
		// boost over, zero interval restarts a kick every beat
		send_sample(1'b1, 7'd50, 32'd1000 + 32'd65535);
		drain_results();
		write_reg(CFG_BOOST_LEN, 16'd0);
		write_reg(CFG_ASSIST_MAX, 16'd0);
		send_sample(1'b1, 7'd1, 32'd70000);
		drain_results();
		write_reg(CFG_ASSIST_MAX, 16'd127);
		write_reg(CFG_KICK_MS, 16'd0);
		send_sample(1'b1, 7'd1, 32'd70010);
		drain_results();
		write_reg(CFG_ASSIST_MAX, 16'd10);
		write_reg(CFG_KICK_MS, 16'hFFFF);
		write_reg(CFG_INTERVAL_MS, 16'hFFFF);
		send_sample(1'b0, 7'd0, 32'd0);
		send_sample(1'b1, 7'd10, 32'd10);
		send_sample(1'b1, 7'd10, 32'd65544);
		// interval reached, kick restarts
		send_sample(1'b1, 7'd10, 32'd65545);
		send_sample(1'b1, 7'd11, 32'd65546);
	endtask

	// random settings per phase, runs of pump-on with advancing time plus noise
	task automatic test_random_traffic();
		int              r;
		int              burst_left;
		logic            en;
		logic [PCT_W-1:0] spd;

		for (int p = 0; p < RAND_PHASES; p++) begin
			drain_results();
			write_reg(CFG_MIN_DUTY, 16'(pick_pct()));
			write_reg(CFG_MAX_DUTY, 16'(pick_pct()));
			write_reg(CFG_BOOST_LEN, pick_ms());
			write_reg(CFG_ASSIST_EN, 16'(p % 3 != 1));
			write_reg(CFG_ASSIST_MAX, 16'(pick_pct()));
			write_reg(CFG_KICK_MS, pick_ms());
			write_reg(CFG_INTERVAL_MS, pick_ms());
			write_reg(CFG_ACTIVE_HIGH, 16'($urandom_range(0, 1)));

			// phase 0 runs without random stalls or sample gaps
			case (p % 4)
				0:       stall_pct = 0;
				1:       stall_pct = 30;
				2:       stall_pct = 60;
				default: stall_pct = 10;
			endcase
			gaps_on    = (p % 3 != 0);
			burst_left = 0;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (gaps_on && burst_left == 0) begin
					pause_sample($urandom_range(1, 8));
					burst_left = $urandom_range(1, 24);
				end
				// long receiver hold-off midway through every other phase
				if (n == PHASE_ITEMS / 2 && p % 2 == 0) hold_req = 1'b1;

				r = $urandom_range(0, 99);
				if (r < 4) sim_ms = $urandom;
				else if (r < 6) sim_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 400));
				else if (r < 12) sim_ms = sim_ms + 32'($urandom_range(0, 70000));
				else sim_ms = sim_ms + 32'($urandom_range(0, 120));

				if ($urandom_range(0, 99) < 7) pump_req = !pump_req;
				en = ($urandom_range(0, 99) < 4) ? 1'($urandom_range(0, 1)) : pump_req;

				r = $urandom_range(0, 9);
				if (r < 4) spd = 7'($urandom_range(0, 12));
				else if (r < 8) spd = 7'($urandom_range(1, 100));
				else spd = 7'($urandom_range(0, 127));

				send_sample(en, spd, sim_ms);
				if (burst_left > 0) burst_left--;
			end
		end
	endtask

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		drive_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req       = 1'b0;
				drive_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			drive_ch.ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// each drive beat against the oldest expectation
	always @(posedge clk) begin : check_drive
		result_t want;

		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			if (expected_drive.size() == 0) begin
				report_fault("drive beat with nothing owed");
			end else begin
				want = expected_drive.pop_front();
				check_field("duty_count", 32'(drive_ch.duty_count), 32'(want.duty_count));
				check_field("running", 32'(drive_ch.running), 32'(want.running));
				check_field("boost_now", 32'(drive_ch.boost_now), 32'(want.boost_now));
				check_field("assist_now", 32'(drive_ch.assist_now), 32'(want.assist_now));
				check_field("mapped_percent", 32'(drive_ch.mapped_percent),
					32'(want.mapped_percent));
			end
		end
	end

	// watchdog on cycles with no beat anywhere
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (drive_ch.valid && drive_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("pump_pwm_boost_assist_drive_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		sample_ch.valid         = 1'b0;
		sample_ch.pump_enable   = 1'b0;
		sample_ch.speed_percent = '0;
		sample_ch.time_ms       = '0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = CFG_MIN_DUTY;
		cfg_ch.data             = '0;

		shadow_cfg.min_duty_percent         = MIN_DUTY_RST;
		shadow_cfg.max_duty_percent         = MAX_DUTY_RST;
		shadow_cfg.boost_len                = BOOST_LEN_RST;
		shadow_cfg.assist_enable            = 1'b0;
		shadow_cfg.assist_max_speed_percent = ASSIST_MAX_RST;
		shadow_cfg.assist_kick_ms           = KICK_MS_RST;
		shadow_cfg.assist_interval_ms       = INTERVAL_RST;
		shadow_cfg.active_high              = 1'b1;
		was_on      = 1'b0;
		boost_armed = 1'b0;
		boost_t0    = '0;
		kick_t0     = '0;
		sim_ms      = '0;
		pump_req    = 1'b1;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_duty_window();
		test_assist_kicks();
		test_random_traffic();

		drain_results();
		repeat (8) @(posedge clk);
		if (fault_count == 0) begin
			$display("pump_pwm_boost_assist_drive_test: PASS");
		end else begin
			$display("pump_pwm_boost_assist_drive_test: FAIL");
		end
		$finish;
	end

endmodule
